### rtl/mtdb_pkg.sv
// Shared types and constants for the timer deadline bank.
// Used by the controller, the datapath and the top level.
package mtdb_pkg;

	localparam logic [2:0] REQ_ADD      = 3'd0;
	localparam logic [2:0] REQ_RESCHED  = 3'd1;
	localparam logic [2:0] REQ_UNSCHED  = 3'd2;
	localparam logic [2:0] REQ_REMOVE   = 3'd3;
	localparam logic [2:0] REQ_EXECUTE  = 3'd4;
	localparam logic [2:0] REQ_QUERY    = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_USED  = 2'd2;

	localparam logic KIND_FIRED = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic [21:0] ONE_HOUR_MS = 22'd3600000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP,
		S_FIRE,
		S_DELAY,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic fire;
		logic scan_step;
		logic scan_clr;
		logic dly_step;
		logic emit_done;
	} dp_cmd_t;

	typedef struct packed {
		logic is_exec;
		logic due;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/multi_timer_deadline_bank.sv
// Top level of the timer deadline bank: controller plus datapath.
// Depends on mtdb_pkg, mtdb_ctrl and mtdb_dp.
//
// Usage: one request beat enters on the input channel (in_valid/in_stall).
// Results leave on the output channel (out_valid/out_stall): zero or more
// fired-event beats (kind 0, execute only, in slot order) and then one
// completion beat (kind 1, last 1) with status and next_delay.
// Each request steps through accept, apply, the fire scan (execute only),
// the delay scan and completion. The slot scans step one slot per cycle
// through a single subtract and compare; the fire scan holds on a due
// slot while the output register cannot take its beat.
// in_stall stays high until the completion beat is loaded, so one request
// is in work at a time. A stalled receiver holds the output register and
// the scan waits on the due slot; nothing is lost.
// Reset clears all in-use and unscheduled marks; slot times need no clear.
module multi_timer_deadline_bank
	import mtdb_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [3:0]  slot,
	input  logic [31:0] now_ms,
	input  logic [30:0] first_interval,
	input  logic [30:0] repeat_interval,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  slot_id,
	output logic [1:0]  status,
	output logic [21:0] next_delay,
	output logic        last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mtdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mtdb_dp #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.slot            (slot),
		.now_ms          (now_ms),
		.first_interval  (first_interval),
		.repeat_interval (repeat_interval),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.slot_id         (slot_id),
		.status          (status),
		.next_delay      (next_delay),
		.last            (last)
	);

endmodule

### rtl/mtdb_ctrl.sv
// Sequencing state machine for the timer deadline bank.
// Depends on mtdb_pkg; drives the datapath through dp_cmd_t.
module mtdb_ctrl
	import mtdb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_OP;
			end
			S_OP: begin
				state_nx = stat.is_exec ? S_FIRE : S_DELAY;
			end
			S_FIRE: begin
				if ((!stat.due || stat.out_free) && stat.scan_last) state_nx = S_DELAY;
			end
			S_DELAY: begin
				if (stat.scan_last) state_nx = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_OP: begin
				cmd.apply    = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			S_FIRE: begin
				// A due slot waits until the output register can take its beat.
				if (!stat.due || stat.out_free) begin
					cmd.fire      = stat.due;
					cmd.scan_step = 1'b1;
					cmd.scan_clr  = stat.scan_last;
				end
			end
			S_DELAY: begin
				cmd.dly_step  = 1'b1;
				cmd.scan_step = 1'b1;
			end
			S_DONE: begin
				cmd.emit_done = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/mtdb_dp.sv
// Datapath of the timer deadline bank: slot storage, scan logic, output register.
// Depends on mtdb_pkg; controlled by mtdb_ctrl.
module mtdb_dp
	import mtdb_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [2:0]  req_type,
	input  logic [3:0]  slot,
	input  logic [31:0] now_ms,
	input  logic [30:0] first_interval,
	input  logic [30:0] repeat_interval,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [3:0]  slot_id,
	output logic [1:0]  status,
	output logic [21:0] next_delay,
	output logic        last
);

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int SW = (IW > 4) ? IW : 4;

	logic [31:0] trig_q [TIMER_SLOTS];
	logic [31:0] rep_q  [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] in_use_q, unsch_q;

	logic [2:0]  type_q;
	logic [3:0]  slot_q;
	logic [31:0] now_q;
	logic [30:0] first_q, repi_q;

	logic [IW-1:0] idx_q;
	logic [21:0]   best_q;
	logic          over_q;

	logic          out_valid_q, kind_q, last_q;
	logic [3:0]    sid_q;
	logic [1:0]    status_q;
	logic [21:0]   delay_q;
	logic [3:0]    res_sid_q;
	logic [1:0]    res_status_q;

	logic [SW-1:0] slot_ext;
	logic [IW-1:0] sidx, ridx, free_idx;
	logic          slot_ok, free_found;
	logic [31:0]   diff;
	logic          live, overdue, out_free;

	assign slot_ext = SW'(slot_q);
	assign sidx     = slot_ext[IW-1:0];
	assign slot_ok  = (32'(slot_q) < 32'(TIMER_SLOTS)) && in_use_q[sidx];
	assign ridx     = idx_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign diff     = trig_q[ridx] - now_q;
	assign live     = in_use_q[ridx] && !unsch_q[ridx];
	assign overdue  = (diff == 32'd0) || diff[31];
	assign out_free = !out_valid_q || !out_stall;

	assign stat.is_exec   = (type_q == REQ_EXECUTE);
	assign stat.due       = live && overdue;
	assign stat.scan_last = (32'(idx_q) == 32'(TIMER_SLOTS - 1));
	assign stat.out_free  = out_free;

	// Request capture and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q  <= req_type;
			slot_q  <= slot;
			now_q   <= now_ms;
			first_q <= first_interval;
			repi_q  <= repeat_interval;
		end
		if (cmd.dly_step && live) begin
			if (!overdue && (diff < 32'(best_q))) best_q <= diff[21:0];
		end
		if (cmd.scan_clr) best_q <= ONE_HOUR_MS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			over_q <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				idx_q  <= '0;
				over_q <= 1'b0;
			end else if (cmd.scan_step) begin
				idx_q <= stat.scan_last ? '0 : idx_q + 1'b1;
				if (cmd.dly_step && live && overdue) over_q <= 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			priority case (1'b1)
				(type_q == REQ_ADD) && free_found: begin
					trig_q[free_idx] <= now_q + {1'b0, first_q};
					rep_q[free_idx]  <= {1'b0, repi_q};
				end
				(type_q == REQ_RESCHED) && slot_ok: begin
					trig_q[sidx] <= now_q + {1'b0, first_q};
					rep_q[sidx]  <= {1'b0, repi_q};
				end
				(type_q == REQ_UNSCHED) && slot_ok: begin
					rep_q[sidx] <= '1;
				end
				default: ;
			endcase
		end
		if (cmd.fire) begin
			trig_q[ridx] <= trig_q[ridx] + rep_q[ridx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			unsch_q      <= '0;
			res_sid_q    <= '0;
			res_status_q <= ST_OK;
		end else begin
			if (cmd.apply) begin
				res_sid_q    <= '0;
				res_status_q <= ST_OK;
				priority case (1'b1)
					type_q == REQ_ADD: begin
						if (free_found) begin
							in_use_q[free_idx] <= 1'b1;
							unsch_q[free_idx]  <= 1'b0;
							res_sid_q          <= 4'(free_idx);
						end else begin
							res_status_q <= ST_NO_FREE;
						end
					end
					(type_q == REQ_RESCHED) || (type_q == REQ_UNSCHED)
						|| (type_q == REQ_REMOVE): begin
						if (!slot_ok) begin
							res_status_q <= ST_NOT_USED;
						end else if (type_q == REQ_RESCHED) begin
							unsch_q[sidx] <= 1'b0;
						end else if (type_q == REQ_UNSCHED) begin
							unsch_q[sidx] <= 1'b1;
						end else begin
							in_use_q[sidx] <= 1'b0;
							unsch_q[sidx]  <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.fire && (rep_q[ridx] == 32'd0)) begin
				in_use_q[ridx] <= 1'b0;
				unsch_q[ridx]  <= 1'b1;
			end
		end
	end

	// Output register; a new beat loads only when the register is empty or its beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fire || cmd.emit_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			kind_q   <= KIND_FIRED;
			sid_q    <= 4'(ridx);
			status_q <= ST_OK;
			delay_q  <= '0;
			last_q   <= 1'b0;
		end else if (cmd.emit_done) begin
			kind_q   <= KIND_DONE;
			sid_q    <= res_sid_q;
			status_q <= res_status_q;
			delay_q  <= over_q ? 22'd0 : best_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign slot_id    = sid_q;
	assign status     = status_q;
	assign next_delay = delay_q;
	assign last       = last_q;

endmodule
